// ===== hdl/ffha_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and constants of the first-fit heap allocator
// Sizes, status codes, request kinds and sequencer states.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int HeapBytes   = 65536;
    localparam int PageBytes   = 4096;
    localparam int HeaderBytes = 8;
    localparam int AddrW       = $clog2(HeapBytes);
    localparam int SizeW       = 17;
    localparam int PageShift   = $clog2(PageBytes);

    localparam logic [SizeW-1:0] UsedMax = {SizeW{1'b1}};

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NOOP    = 2'd1,
        ST_OOM     = 2'd2,
        ST_CORRUPT = 2'd3
    } status_t;

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } kind_t;

    typedef enum logic {
        REG_HEAP_LIMIT = 1'b0,
        REG_MIN_CHUNK  = 1'b1
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_READ,
        S_A_CHECK,
        S_A_SPLIT,
        S_A_MARK,
        S_F_READ,
        S_F_CHECK,
        S_F_NREAD,
        S_F_NCHECK,
        S_F_WRITE,
        S_REPLY
    } state_t;

    // Memory command from sequencer to the chunk store
    typedef struct packed {
        logic             wr;
        logic [AddrW-1:0] addr;
        logic [SizeW-1:0] size;
        logic             used;
    } mem_cmd_t;

endpackage : ffha_pkg
`default_nettype wire

// ===== hdl/ffha_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_store: chunk header memory
// One port: size and used mark per byte offset, registered read data.
// ----------------------------------------------------------------------------
module ffha_store (
    input  wire logic                           clk,
    input  wire ffha_pkg::mem_cmd_t             cmd,
    output logic [ffha_pkg::SizeW-1:0]          rd_size,
    output logic                                rd_used
);

    logic [ffha_pkg::SizeW:0] mem [ffha_pkg::HeapBytes];

    // Write or read one header per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[cmd.addr] <= {cmd.used, cmd.size};
        end
        {rd_used, rd_size} <= mem[cmd.addr];
    end

endmodule : ffha_store
`default_nettype wire

// ===== hdl/first_fit_heap_allocator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core: first-fit allocator over a header memory
// Allocates by walking chunk headers from offset 0, frees with forward merge.
// ----------------------------------------------------------------------------
// Allocate checks each chunk header visited, may split off the leftover and marks
// the chunk used; free checks its header, merges following free chunks up to a used one
// or the heap top, writes the merged header; no-ops and bad offsets reply directly.
// One request at a time, busy high until the result beat; the single-port header
// memory sets the rate. Reset clears control state; offset 0 reads as a free page
// until first written, so no clearing pass. Results last one cycle, no stall.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        kind,
    input  wire logic [15:0] request_bytes,
    input  wire logic [15:0] release_offset,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [16:0] cfg_data,
    output logic             done,
    output logic [15:0]      payload_offset,
    output logic [1:0]       status,
    output logic [16:0]      used_total
);

    localparam int AW = ffha_pkg::AddrW;
    localparam int SW = ffha_pkg::SizeW;

    ffha_pkg::state_t state_reg, state_next;

    logic [16:0]   limit_reg;
    logic [12:0]   minc_reg;
    logic [SW-1:0] top_reg, top_next;
    logic [SW-1:0] inuse_reg, inuse_next;
    logic          first_wr_reg, first_wr_next;
    logic [SW-1:0] total_reg, total_next;
    logic [SW-1:0] pos_reg, pos_next;
    logic [SW-1:0] sz_reg, sz_next;
    logic [1:0]    st_reg, st_next;
    logic [15:0]   pay_reg, pay_next;

    ffha_pkg::mem_cmd_t cmd;
    logic [SW-1:0] m_size;
    logic          m_used;
    logic [SW-1:0] rd_size;
    logic          rd_used;
    logic [AW-1:0] rd_addr_reg;

    // Shared adder/compare operands
    logic [SW:0]   sum;
    logic [SW-1:0] minc;
    logic [SW-1:0] lim;
    logic [SW:0]   grow;

    ffha_store u_store (
        .clk     (clk),
        .cmd     (cmd),
        .rd_size (m_size),
        .rd_used (m_used)
    );

    // Offset 0 reads as the reset page until first written
    assign rd_size = (rd_addr_reg == '0 && !first_wr_reg)
                     ? SW'(ffha_pkg::PageBytes) : m_size;
    assign rd_used = (rd_addr_reg == '0 && !first_wr_reg) ? 1'b0 : m_used;

    assign minc = (minc_reg == '0) ? SW'(1) : SW'(minc_reg);
    assign lim  = (limit_reg < 17'(ffha_pkg::HeapBytes)) ? limit_reg
                                                        : SW'(ffha_pkg::HeapBytes);
    assign grow = (SW+1)'(((total_reg >> ffha_pkg::PageShift) + SW'(1))
                          << ffha_pkg::PageShift);

    // Configuration and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ffha_pkg::S_IDLE;
            limit_reg    <= 17'd65536;
            minc_reg     <= 13'd16;
            top_reg      <= SW'(ffha_pkg::PageBytes);
            inuse_reg    <= '0;
            first_wr_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            top_reg      <= top_next;
            inuse_reg    <= inuse_next;
            first_wr_reg <= first_wr_next;
            if (cfg_we)
            begin
                unique case (ffha_pkg::reg_idx_t'(cfg_index))
                    ffha_pkg::REG_HEAP_LIMIT: limit_reg <= cfg_data;
                    ffha_pkg::REG_MIN_CHUNK:  minc_reg  <= cfg_data[12:0];
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        total_reg   <= total_next;
        pos_reg     <= pos_next;
        sz_reg      <= sz_next;
        st_reg      <= st_next;
        pay_reg     <= pay_next;
        rd_addr_reg <= cmd.addr;
    end

    // Next state and datapath
    always_comb
    begin
        state_next    = state_reg;
        top_next      = top_reg;
        inuse_next    = inuse_reg;
        first_wr_next = first_wr_reg;
        total_next    = total_reg;
        pos_next      = pos_reg;
        sz_next       = sz_reg;
        st_next       = st_reg;
        pay_next      = pay_reg;
        cmd.wr        = 1'b0;
        cmd.addr      = pos_reg[AW-1:0];
        cmd.size      = sz_reg;
        cmd.used      = 1'b0;
        sum           = '0;
        unique case (state_reg)
            ffha_pkg::S_IDLE:
            begin
                if (start)
                begin
                    pay_next = '0;
                    if (ffha_pkg::kind_t'(kind) == ffha_pkg::KIND_ALLOC)
                    begin
                        sum        = (SW+1)'(request_bytes) + (SW+1)'(ffha_pkg::HeaderBytes);
                        total_next = (sum[SW-1:0] < minc) ? minc : sum[SW-1:0];
                        pos_next   = '0;
                        if (request_bytes == '0)
                        begin
                            st_next    = ffha_pkg::ST_NOOP;
                            state_next = ffha_pkg::S_REPLY;
                        end
                        else
                        begin
                            cmd.addr   = '0;
                            state_next = ffha_pkg::S_A_CHECK;
                        end
                    end
                    else
                    begin
                        pos_next = SW'(release_offset) - SW'(ffha_pkg::HeaderBytes);
                        if (release_offset == '0)
                        begin
                            st_next    = ffha_pkg::ST_NOOP;
                            state_next = ffha_pkg::S_REPLY;
                        end
                        else if (release_offset < 16'(ffha_pkg::HeaderBytes)
                                 || pos_next >= top_reg)
                        begin
                            st_next    = ffha_pkg::ST_CORRUPT;
                            state_next = ffha_pkg::S_REPLY;
                        end
                        else
                        begin
                            cmd.addr   = pos_next[AW-1:0];
                            state_next = ffha_pkg::S_F_CHECK;
                        end
                    end
                end
            end
            ffha_pkg::S_A_READ:
            begin
                // Issue header read at pos
                state_next = ffha_pkg::S_A_CHECK;
            end
            ffha_pkg::S_A_CHECK:
            begin
                sum     = (SW+1)'(pos_reg) + (SW+1)'(rd_size);
                sz_next = rd_size;
                if (rd_size == '0 || sum > (SW+1)'(top_reg))
                begin
                    st_next    = ffha_pkg::ST_CORRUPT;
                    state_next = ffha_pkg::S_REPLY;
                end
                else if (!rd_used && rd_size >= total_reg)
                begin
                    state_next = (rd_size - total_reg >= minc) ? ffha_pkg::S_A_SPLIT
                                                               : ffha_pkg::S_A_MARK;
                end
                else if (sum[SW-1:0] == top_reg)
                begin
                    // Walk hit the top: grow by whole pages
                    if ((SW+1)'(top_reg) + grow > (SW+1)'(lim))
                    begin
                        st_next    = ffha_pkg::ST_OOM;
                        state_next = ffha_pkg::S_REPLY;
                    end
                    else
                    begin
                        pos_next   = sum[SW-1:0];
                        cmd.wr     = 1'b1;
                        cmd.addr   = sum[AW-1:0];
                        cmd.size   = grow[SW-1:0];
                        cmd.used   = 1'b0;
                        top_next   = top_reg + grow[SW-1:0];
                        state_next = ffha_pkg::S_A_READ;
                    end
                end
                else
                begin
                    pos_next   = sum[SW-1:0];
                    state_next = ffha_pkg::S_A_READ;
                end
            end
            ffha_pkg::S_A_SPLIT:
            begin
                // Write the leftover free chunk
                sum        = (SW+1)'(pos_reg) + (SW+1)'(total_reg);
                cmd.wr     = 1'b1;
                cmd.addr   = sum[AW-1:0];
                cmd.size   = sz_reg - total_reg;
                cmd.used   = 1'b0;
                sz_next    = total_reg;
                state_next = ffha_pkg::S_A_MARK;
            end
            ffha_pkg::S_A_MARK:
            begin
                cmd.wr   = 1'b1;
                cmd.used = 1'b1;
                if (pos_reg[AW-1:0] == '0)
                begin
                    first_wr_next = 1'b1;
                end
                sum        = (SW+1)'(inuse_reg) + (SW+1)'(sz_reg);
                inuse_next = sum[SW] ? ffha_pkg::UsedMax : sum[SW-1:0];
                pay_next   = 16'(pos_reg + SW'(ffha_pkg::HeaderBytes));
                st_next    = ffha_pkg::ST_DONE;
                state_next = ffha_pkg::S_REPLY;
            end
            ffha_pkg::S_F_READ:
            begin
                state_next = ffha_pkg::S_F_CHECK;
            end
            ffha_pkg::S_F_CHECK:
            begin
                sz_next = rd_size;
                if (rd_size == '0)
                begin
                    st_next    = ffha_pkg::ST_CORRUPT;
                    state_next = ffha_pkg::S_REPLY;
                end
                else
                begin
                    inuse_next = (rd_size > inuse_reg) ? '0 : inuse_reg - rd_size;
                    st_next    = ffha_pkg::ST_DONE;
                    state_next = ffha_pkg::S_F_NREAD;
                end
            end
            ffha_pkg::S_F_NREAD:
            begin
                // Read the following header, or finish at the top
                sum = (SW+1)'(pos_reg) + (SW+1)'(sz_reg);
                if (sum >= (SW+1)'(top_reg))
                begin
                    state_next = ffha_pkg::S_F_WRITE;
                end
                else
                begin
                    cmd.addr   = sum[AW-1:0];
                    state_next = ffha_pkg::S_F_NCHECK;
                end
            end
            ffha_pkg::S_F_NCHECK:
            begin
                if (rd_used)
                begin
                    state_next = ffha_pkg::S_F_WRITE;
                end
                else if (rd_size == '0)
                begin
                    st_next    = ffha_pkg::ST_CORRUPT;
                    state_next = ffha_pkg::S_F_WRITE;
                end
                else
                begin
                    sz_next    = sz_reg + rd_size;
                    state_next = ffha_pkg::S_F_NREAD;
                end
            end
            ffha_pkg::S_F_WRITE:
            begin
                // Store merged size with used mark cleared
                cmd.wr = 1'b1;
                if (pos_reg[AW-1:0] == '0)
                begin
                    first_wr_next = 1'b1;
                end
                state_next = ffha_pkg::S_REPLY;
            end
            ffha_pkg::S_REPLY:
            begin
                state_next = ffha_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ffha_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        busy           = (state_reg != ffha_pkg::S_IDLE);
        done           = (state_reg == ffha_pkg::S_REPLY);
        payload_offset = pay_reg;
        status         = st_reg;
        used_total     = inuse_reg;
    end

endmodule : first_fit_heap_allocator_core
`default_nettype wire
